@@ rtl/core/prlt_pkg.sv @@
package prlt_pkg;

    localparam int KEY_BITS   = 17;
    localparam int ID_BITS    = 16;
    localparam int TAG_BITS   = 16;
    localparam int SEC_BITS   = 32;
    localparam int NS_BITS    = 30;
    localparam int LAT_BITS   = SEC_BITS + 1;
    localparam int DEPTH      = 1 << KEY_BITS;
    localparam int CNT_BITS   = KEY_BITS + 1;
    localparam int MODE_BITS  = 2;
    localparam int STAT_BITS  = 3;

    localparam logic [NS_BITS-1:0] NS_PER_S = NS_BITS'(1000000000);
    localparam logic [KEY_BITS-1:0] ADDR_MAX = {KEY_BITS{1'b1}};

    localparam logic [MODE_BITS-1:0] MODE_START = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REPLY = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PURGE = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_STARTED   = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_ON_TIME   = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_LATE      = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_PURGED    = 3'd4;

    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] target;
        logic [SEC_BITS-1:0] req_s;
        logic [NS_BITS-1:0]  req_ns;
    } t_entry;

    typedef struct packed {
        logic                late;
        logic [LAT_BITS-1:0] lat_s;
        logic [NS_BITS-1:0]  lat_ns;
    } t_reply;

endpackage

@@ rtl/core/prlt_reply.sv @@
module prlt_reply (
    input  logic                           i_clk,
    input  logic [prlt_pkg::SEC_BITS-1:0]  i_now_s,
    input  logic [prlt_pkg::NS_BITS-1:0]   i_now_ns,
    input  logic [prlt_pkg::SEC_BITS-1:0]  i_req_s,
    input  logic [prlt_pkg::NS_BITS-1:0]   i_req_ns,
    input  logic [prlt_pkg::SEC_BITS-1:0]  i_ttl,
    output prlt_pkg::t_reply               o_res
);
    import prlt_pkg::*;

    logic [SEC_BITS-1:0] n_mag;
    logic                n_borrow;
    logic [NS_BITS-1:0]  n_diff;
    logic [NS_BITS-1:0]  n_ns;

    logic [SEC_BITS-1:0] r_mag;
    logic                r_borrow;
    logic [NS_BITS-1:0]  r_ns;

    logic                neg_one;
    logic [SEC_BITS-1:0] mag_dec;

    // first stage: magnitude of the seconds gap and the nanosecond borrow
    always_comb begin
        n_mag    = (i_now_s > i_req_s) ? (i_now_s - i_req_s) : (i_req_s - i_now_s);
        n_borrow = (i_now_ns < i_req_ns);
        n_diff   = i_now_ns - i_req_ns;
        n_ns     = n_borrow ? (n_diff + NS_PER_S) : n_diff;
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_borrow <= n_borrow;
        r_ns     <= n_ns;
    end

    // second stage: apply the borrow; mag-1 >= ttl is the same as mag > ttl
    always_comb begin
        neg_one      = r_borrow && (r_mag == '0);
        mag_dec      = r_mag - SEC_BITS'(1);
        o_res.late   = r_borrow ? (r_mag > i_ttl) : (r_mag >= i_ttl);
        o_res.lat_s  = neg_one ? {LAT_BITS{1'b1}}
                     : {1'b0, (r_borrow ? mag_dec : r_mag)};
        o_res.lat_ns = r_ns;
    end

endmodule

@@ rtl/core/probe_reply_latency_table_unit.sv @@
// Probe reply latency table. Outstanding probe requests sit in a 131072-entry
// single-port-write, single-port-read RAM addressed by probe_id + sequence_number.
// After reset the block clears the whole RAM with input stall high; configuration
// writes are taken during that time. A start request passes through a write state
// and an output load; a reply through a RAM read, two arithmetic stages with the
// write-back in the second, and an output load. A purge sweeps the whole RAM one
// entry per cycle. One request is in flight at a time; a finished result waits in
// the output register while the next request is taken. Mode 3 requests are
// accepted and produce no result.
module probe_reply_latency_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [prlt_pkg::MODE_BITS-1:0]  i_mode,
    input  logic [prlt_pkg::ID_BITS-1:0]    i_probe_id,
    input  logic [prlt_pkg::ID_BITS-1:0]    i_sequence_number,
    input  logic [prlt_pkg::SEC_BITS-1:0]   i_stamp_seconds,
    input  logic [prlt_pkg::NS_BITS-1:0]    i_stamp_nanoseconds,
    input  logic [prlt_pkg::TAG_BITS-1:0]   i_target_tag,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [prlt_pkg::STAT_BITS-1:0]  o_status,
    output logic [prlt_pkg::TAG_BITS-1:0]   o_matched_target,
    output logic signed [prlt_pkg::LAT_BITS-1:0] o_latency_seconds,
    output logic [prlt_pkg::NS_BITS-1:0]    o_latency_nanoseconds,
    output logic [prlt_pkg::CNT_BITS-1:0]   o_purged_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prlt_pkg::SEC_BITS-1:0]   i_cfg_data
);
    import prlt_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_WRITE     = 9'b000000100,
        S_READ      = 9'b000001000,
        S_CALC      = 9'b000010000,
        S_JUDGE     = 9'b000100000,
        S_SCAN      = 9'b001000000,
        S_SCAN_LAST = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [SEC_BITS-1:0]  r_ttl;
    logic [MODE_BITS-1:0] r_mode;
    logic [KEY_BITS-1:0]  r_key;
    logic [SEC_BITS-1:0]  r_now_s;
    logic [NS_BITS-1:0]   r_now_ns;
    logic [TAG_BITS-1:0]  r_tag;

    logic [KEY_BITS-1:0]  r_addr;
    logic                 r_chk;
    logic [KEY_BITS-1:0]  r_chk_addr;
    logic [CNT_BITS-1:0]  r_count;

    t_entry               r_mem [DEPTH];
    t_entry               r_rd_data;
    logic                 rd_en;
    logic [KEY_BITS-1:0]  rd_addr;
    logic                 we;
    logic [KEY_BITS-1:0]  waddr;
    t_entry               wdata;
    logic                 expire;

    logic [STAT_BITS-1:0] r_status;
    logic [TAG_BITS-1:0]  r_target;
    logic [LAT_BITS-1:0]  r_lat_s;
    logic [NS_BITS-1:0]   r_lat_ns;

    logic                 r_out_valid;
    logic                 accept;
    logic                 out_free;
    t_reply               reply;

    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign out_free    = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:     if (r_addr == ADDR_MAX) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid) begin
                    case (i_mode)
                        MODE_START: n_state = S_WRITE;
                        MODE_REPLY: n_state = S_READ;
                        MODE_PURGE: n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE:     n_state = S_DONE;
            S_READ:      n_state = S_CALC;
            S_CALC:      n_state = S_JUDGE;
            S_JUDGE:     n_state = S_DONE;
            S_SCAN:      if (r_addr == ADDR_MAX) n_state = S_SCAN_LAST;
            S_SCAN_LAST: n_state = S_DONE;
            S_DONE:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ttl <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_key    <= KEY_BITS'({1'b0, i_probe_id} + {1'b0, i_sequence_number});
            r_now_s  <= i_stamp_seconds;
            r_now_ns <= i_stamp_nanoseconds;
            r_tag    <= i_target_tag;
        end
    end

    // shared address counter: clearing sweep after reset, then purge sweeps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_chk   <= 1'b0;
            r_count <= '0;
        end else begin
            r_chk <= (r_state == S_SCAN);
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_addr <= r_addr + KEY_BITS'(1);
            end else if (accept) begin
                r_addr <= '0;
            end
            if (accept) begin
                r_count <= '0;
            end else if (expire) begin
                r_count <= r_count + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= r_addr;
    end

    // RAM: one write and one registered read per cycle
    assign rd_en   = (r_state == S_READ) || (r_state == S_SCAN);
    assign rd_addr = (r_state == S_READ) ? r_key : r_addr;

    always_comb begin
        expire = r_chk && r_rd_data.valid
              && (({1'b0, r_rd_data.req_s} + {1'b0, r_ttl}) <= {1'b0, r_now_s});
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_key;
        wdata = '0;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_addr;
            end
            S_WRITE: begin
                we           = 1'b1;
                wdata.valid  = 1'b1;
                wdata.target = r_tag;
                wdata.req_s  = r_now_s;
                wdata.req_ns = r_now_ns;
            end
            S_JUDGE: begin
                we = r_rd_data.valid;
            end
            S_SCAN, S_SCAN_LAST: begin
                we    = expire;
                waddr = r_chk_addr;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    prlt_reply u_reply (
        .i_clk    (i_clk),
        .i_now_s  (r_now_s),
        .i_now_ns (r_now_ns),
        .i_req_s  (r_rd_data.req_s),
        .i_req_ns (r_rd_data.req_ns),
        .i_ttl    (r_ttl),
        .o_res    (reply)
    );

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_WRITE: begin
                r_status <= ST_STARTED;
                r_target <= '0;
                r_lat_s  <= '0;
                r_lat_ns <= '0;
            end
            S_JUDGE: begin
                if (r_rd_data.valid) begin
                    r_status <= reply.late ? ST_LATE : ST_ON_TIME;
                    r_target <= r_rd_data.target;
                    r_lat_s  <= reply.lat_s;
                    r_lat_ns <= reply.lat_ns;
                end else begin
                    r_status <= ST_NOT_FOUND;
                    r_target <= '0;
                    r_lat_s  <= '0;
                    r_lat_ns <= '0;
                end
            end
            S_SCAN_LAST: begin
                r_status <= ST_PURGED;
                r_target <= '0;
                r_lat_s  <= '0;
                r_lat_ns <= '0;
            end
            default: begin
                r_status <= r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_status              <= r_status;
            o_matched_target      <= r_target;
            o_latency_seconds     <= r_lat_s;
            o_latency_nanoseconds <= r_lat_ns;
            o_purged_count        <= (r_mode == MODE_PURGE) ? r_count : '0;
        end
    end

endmodule
